@@ design/i2cbed_pkg.sv @@
// Shared types and constants for the I2C bus event decoder.
package i2cbed_pkg;

	localparam int unsigned BitCntW = 4;
	localparam logic [BitCntW-1:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [2:0] {
		EV_START = 3'd0,
		EV_STOP  = 3'd1,
		EV_BYTE  = 3'd2,
		EV_ACK   = 3'd3,
		EV_NACK  = 3'd4
	} event_kind_t;

	typedef struct packed {
		logic        clock_level;
		logic        data_level;
		logic [31:0] sample_time;
		logic        first_of_capture;
	} sample_t;

	typedef struct packed {
		event_kind_t event_kind;
		logic [7:0]  data_byte;
		logic [6:0]  device_address;
		logic        read_not_write;
		logic        is_address_byte;
		logic [31:0] event_time;
	} bus_event_t;

	typedef struct packed {
		logic               last_clock;
		logic               last_data;
		logic               frame_open;
		logic [7:0]         shift_byte;
		logic [BitCntW-1:0] bits_taken;
		logic               awaiting_first_byte;
	} dec_state_t;

	localparam dec_state_t DEC_STATE_RESET = '{
		last_clock:          1'b1,
		last_data:           1'b1,
		frame_open:          1'b0,
		shift_byte:          8'd0,
		bits_taken:          '0,
		awaiting_first_byte: 1'b0
	};

endpackage

@@ design/i2c_bus_event_decoder_unit.sv @@
// I2C bus event decoder: line samples in, START/STOP/BYTE/ACK/NACK events out.
//
// Each transaction on the sample channel carries one timestamped sample of the
// clock and data lines; a sample causes at most one event transaction. Samples
// are taken one per clock cycle unless the channel stalls. A sample is held
// in an input register, decoded against the stored bus state, and its event
// lands in an output register, which drives the event channel. The output
// register lets a new sample be taken while an event waits; the sample channel
// stalls only when an event is pending and the next sample would produce
// another one.
module i2c_bus_event_decoder_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   smp_valid,
	output logic                   smp_ready,
	input  i2cbed_pkg::sample_t    smp,
	output logic                   evt_valid,
	input  logic                   evt_ready,
	output i2cbed_pkg::bus_event_t evt
);

	logic                   valid_s1;
	i2cbed_pkg::sample_t    smp_s1;
	i2cbed_pkg::dec_state_t state_q;
	i2cbed_pkg::dec_state_t state_next;
	logic                   dec_ev_valid;
	i2cbed_pkg::bus_event_t dec_ev;
	logic                   out_free;
	logic                   consume_s1;
	logic                   evt_valid_q;
	i2cbed_pkg::bus_event_t evt_q;

	i2cbed_decode u_decode (
		.st       (state_q),
		.smp      (smp_s1),
		.st_next  (state_next),
		.ev_valid (dec_ev_valid),
		.ev       (dec_ev)
	);

	assign out_free   = ~evt_valid_q | evt_ready;
	// A sample with no event leaves the stage even while the output is blocked.
	assign consume_s1 = valid_s1 & (~dec_ev_valid | out_free);
	assign smp_ready  = ~valid_s1 | consume_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (smp_ready) begin
			valid_s1 <= smp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (smp_ready && smp_valid) begin
			smp_s1 <= smp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2cbed_pkg::DEC_STATE_RESET;
		end else if (consume_s1) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (out_free) begin
			evt_valid_q <= consume_s1 & dec_ev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && consume_s1 && dec_ev_valid) begin
			evt_q <= dec_ev;
		end
	end

	assign evt_valid = evt_valid_q;
	assign evt       = evt_q;

endmodule

@@ design/i2cbed_decode.sv @@
// Combinational bus event decode: next decoder state and the event of one sample.
module i2cbed_decode (
	input  i2cbed_pkg::dec_state_t st,
	input  i2cbed_pkg::sample_t    smp,
	output i2cbed_pkg::dec_state_t st_next,
	output logic                   ev_valid,
	output i2cbed_pkg::bus_event_t ev
);

	logic                               start_cond;
	logic                               stop_cond;
	logic                               rise_cond;
	logic [i2cbed_pkg::BitCntW-1:0]     bits_inc;
	logic [7:0]                         shifted;

	assign start_cond = st.last_clock & smp.clock_level & st.last_data & ~smp.data_level;
	assign stop_cond  = st.last_clock & smp.clock_level & ~st.last_data & smp.data_level;
	assign rise_cond  = ~st.last_clock & smp.clock_level & st.frame_open;
	assign bits_inc   = st.bits_taken + 1'b1;
	assign shifted    = {st.shift_byte[6:0], smp.data_level};

	always_comb begin
		st_next            = st;
		st_next.last_clock = smp.clock_level;
		st_next.last_data  = smp.data_level;
		ev_valid           = 1'b0;
		ev                 = '0;
		ev.event_kind      = i2cbed_pkg::EV_START;
		ev.event_time      = smp.sample_time;

		if (smp.first_of_capture) begin
			st_next.frame_open          = 1'b0;
			st_next.shift_byte          = '0;
			st_next.bits_taken          = '0;
			st_next.awaiting_first_byte = 1'b0;
		end else if (start_cond) begin
			ev_valid                    = 1'b1;
			ev.event_kind               = i2cbed_pkg::EV_START;
			st_next.shift_byte          = '0;
			st_next.bits_taken          = '0;
			st_next.frame_open          = 1'b1;
			st_next.awaiting_first_byte = 1'b1;
		end else if (stop_cond) begin
			ev_valid           = 1'b1;
			ev.event_kind      = i2cbed_pkg::EV_STOP;
			st_next.frame_open = 1'b0;
		end else if (rise_cond) begin
			if (st.bits_taken < i2cbed_pkg::BITS_PER_BYTE) begin
				st_next.shift_byte = shifted;
				st_next.bits_taken = bits_inc;
				// The eighth bit completes the byte; the next rise is the acknowledge.
				if (bits_inc == i2cbed_pkg::BITS_PER_BYTE) begin
					ev_valid                    = 1'b1;
					ev.event_kind               = i2cbed_pkg::EV_BYTE;
					ev.data_byte                = shifted;
					ev.device_address           = shifted[7:1];
					ev.read_not_write           = shifted[0];
					ev.is_address_byte          = st.awaiting_first_byte;
					st_next.awaiting_first_byte = 1'b0;
				end
			end else begin
				ev_valid           = 1'b1;
				ev.event_kind      = smp.data_level ? i2cbed_pkg::EV_NACK
				                                    : i2cbed_pkg::EV_ACK;
				st_next.shift_byte = '0;
				st_next.bits_taken = '0;
			end
		end
	end

endmodule
